@@ design/vrbq_pkg.sv @@
package vrbq_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] len_t;
  typedef logic [2:0] kind_t;

  localparam int KIND_COUNT = 8;
  localparam int LANES_MAX  = 8;
  localparam int CFG_IDX_W  = 4;

  // per-lane control from the sequencer
  typedef struct packed {
    logic  clr;   // start of a transaction: reload or clear
    logic  push;  // with clr: take payload byte, else zero
    logic  cap;   // capture read data
    kind_t sel;   // lane that captures
  } lane_ctrl_t;

  // record length with zero taken as one and large values saturated
  function automatic len_t len_of(input len_t raw, input len_t cap);
    len_t n;
    n = raw;
    if (n == '0) n = len_t'(1);
    if (n > cap) n = cap;
    return n;
  endfunction

endpackage

@@ design/vrbq_ring.sv @@
module vrbq_ring #(
  parameter int QUEUE_BYTES = 1024,
  parameter int AW          = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  vrbq_pkg::byte_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output vrbq_pkg::byte_t rdata
);
  import vrbq_pkg::*;

  byte_t mem [QUEUE_BYTES];
  byte_t rdata_r;

  // byte ring, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/vrbq_lane.sv @@
module vrbq_lane #(
  parameter int LANE = 0
) (
  input  logic                 clk,
  input  vrbq_pkg::lane_ctrl_t ctrl,
  input  vrbq_pkg::byte_t      pay_byte,
  input  vrbq_pkg::byte_t      rd_byte,
  output vrbq_pkg::byte_t      lane_byte
);
  import vrbq_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  // one payload byte slot: loaded on push, filled from the ring on pop
  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clr) begin
      byte_nxt = ctrl.push ? pay_byte : '0;
    end else if (ctrl.cap && ctrl.sel == kind_t'(LANE)) begin
      byte_nxt = rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign lane_byte = byte_r;

endmodule

@@ design/variable_record_byte_ring_queue.sv @@
// Push: S_WR writes the type byte and payload bytes, then S_FIN; a dropped push goes straight
// to S_FIN. Pop: S_IDLE reads the type byte, S_PTYPE decodes kind and length, S_PPAY reads
// the payload, then S_FIN; an empty pop goes straight to S_FIN. S_FIN registers the result
// once the output register is free, where it holds until taken. One transaction at a time;
// the ring port moves one byte per cycle. Synchronous active-low reset clears pointers,
// counters, peak and lengths (to 1); ring contents are not cleared, no clearing pass needed.
module variable_record_byte_ring_queue #(
  parameter int QUEUE_BYTES       = 1024,
  parameter int MAX_PAYLOAD_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vrbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]                     cfg_data,
  // requests
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // event_payload
  input  logic [3:0]                     in_tuser,   // req_type, event_kind[3:1]
  // results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // popped_payload[63:0], overrun_count[95:64], used_bytes[105:96],
  // used_peak[115:106], zero pad[119:116]
  output logic [119:0]                   out_tdata,
  // pop_valid[0], popped_kind[3:1], push_accepted[4]
  output logic [4:0]                     out_tuser
);
  import vrbq_pkg::*;

  localparam int PW = $clog2(QUEUE_BYTES);
  localparam logic [PW:0]   QCNT    = (PW+1)'(QUEUE_BYTES);
  localparam logic [PW-1:0] PMAX    = PW'(QUEUE_BYTES - 1);
  localparam len_t          LEN_CAP = len_t'(MAX_PAYLOAD_BYTES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR    = 3'd1;
  localparam logic [2:0] S_PTYPE = 3'd2;
  localparam logic [2:0] S_PPAY  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic REQ_PUSH = 1'b0;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW-1:0] occ_r, peak_r, peak_nxt;
  logic [31:0]   drop_r, drop_nxt;
  len_t          n_r, n_nxt;
  len_t          cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  kind_t         pend_lane_r, pend_lane_nxt;
  logic          pv_r, pv_nxt, acc_r, acc_nxt;
  kind_t         kind_r, kind_nxt;
  len_t          rec_len_r [KIND_COUNT];
  logic          out_valid_r, out_valid_nxt;
  logic [119:0]  out_tdata_r, out_tdata_nxt;
  logic [4:0]    out_tuser_r, out_tuser_nxt;

  logic          mem_we, mem_re;
  byte_t         mem_wdata, mem_rdata;
  lane_ctrl_t    lane_ctrl;
  byte_t         lane_byte [LANES_MAX];
  logic [63:0]   lane_payload;

  logic [PW:0]   diff;
  logic [PW-1:0] occ;
  logic          req;
  kind_t         in_kind;
  len_t          push_len;

  assign req     = in_tuser[0];
  assign in_kind = in_tuser[3:1];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PMAX) ? '0 : p + 1'b1;
  endfunction

  // occupancy modulo ring size
  assign diff = {1'b0, wp_r} - {1'b0, rp_r};
  assign occ  = diff[PW] ? PW'(diff + QCNT) : diff[PW-1:0];

  // ring memory
  vrbq_ring #(.QUEUE_BYTES(QUEUE_BYTES), .AW(PW)) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rp_r),
    .rdata (mem_rdata)
  );

  // payload byte lanes and merge
  for (genvar g = 0; g < LANES_MAX; g++) begin : g_lane
    if (g < MAX_PAYLOAD_BYTES) begin : g_on
      vrbq_lane #(.LANE(g)) u_lane (
        .clk       (clk),
        .ctrl      (lane_ctrl),
        .pay_byte  (in_tdata[8*g +: 8]),
        .rd_byte   (mem_rdata),
        .lane_byte (lane_byte[g])
      );
    end else begin : g_off
      assign lane_byte[g] = '0;
    end
    assign lane_payload[8*g +: 8] = lane_byte[g];
  end

  // length registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KIND_COUNT; k++) begin
        rec_len_r[k] <= len_t'(1);
      end
    end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(KIND_COUNT)) begin
      rec_len_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign push_len  = len_of(rec_len_r[in_kind], LEN_CAP);
  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    peak_nxt      = peak_r;
    drop_nxt      = drop_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_lane_nxt = pend_lane_r;
    pv_nxt        = pv_r;
    acc_nxt       = acc_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = '0;
    lane_ctrl     = '{clr: 1'b0, push: 1'b0, cap: pend_r, sel: pend_lane_r};

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          lane_ctrl.clr  = 1'b1;
          lane_ctrl.push = (req == REQ_PUSH);
          pv_nxt         = 1'b0;
          acc_nxt        = 1'b0;
          kind_nxt       = in_kind;
          cnt_nxt        = '0;
          if (req == REQ_PUSH) begin
            if (occ_r > peak_r) peak_nxt = occ_r;
            if (({1'b0, occ_r} + (PW+1)'(push_len)) < QCNT) begin
              n_nxt     = push_len;
              acc_nxt   = 1'b1;
              state_nxt = S_WR;
            end else begin
              drop_nxt  = drop_r + 32'd1;
              state_nxt = S_FIN;
            end
          end else if (wp_r != rp_r) begin
            mem_re    = 1'b1;
            rp_nxt    = ptr_inc(rp_r);
            state_nxt = S_PTYPE;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt_r == '0) ? byte_t'(kind_r) : lane_byte[kind_t'(cnt_r - 1'b1)];
        wp_nxt    = ptr_inc(wp_r);
        if (cnt_r == n_r - 1'b1) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PTYPE: begin
        kind_nxt  = mem_rdata[2:0];
        n_nxt     = len_of(rec_len_r[mem_rdata[2:0]], LEN_CAP) - 1'b1;
        cnt_nxt   = '0;
        pv_nxt    = 1'b1;
        state_nxt = S_PPAY;
      end
      S_PPAY: begin
        // payload reads overlap with captures, each byte captured in the cycle after its read
        if (cnt_r != n_r) begin
          mem_re        = 1'b1;
          rp_nxt        = ptr_inc(rp_r);
          pend_nxt      = 1'b1;
          pend_lane_nxt = cnt_r[2:0];
          cnt_nxt       = cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {4'b0, 10'(peak_r), 10'(occ), drop_r,
                           pv_r ? lane_payload : 64'd0};
          out_tuser_nxt = {acc_r, pv_r ? kind_r : kind_t'(0), pv_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      occ_r       <= '0;
      peak_r      <= '0;
      drop_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      occ_r       <= occ;
      peak_r      <= peak_nxt;
      drop_r      <= drop_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    pend_lane_r <= pend_lane_nxt;
    pv_r        <= pv_nxt;
    acc_r       <= acc_nxt;
    kind_r      <= kind_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

@@ sim/ring_queue_checker.sv @@
`timescale 1ns / 1ps

module ring_queue_checker #(
  parameter int QUEUE_BYTES       = 1024,
  parameter int MAX_PAYLOAD_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [vrbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]                     cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // event_payload
  input  logic [3:0]                     in_tuser,   // req_type, event_kind
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // popped_payload, overrun_count, used_bytes, used_peak, zero pad
  input  logic [119:0]                   out_tdata,
  // pop_valid, popped_kind, push_accepted
  input  logic [4:0]                     out_tuser,
  output int                             mismatches,
  output int                             outstanding
);

  localparam logic REQ_POP = 1'b1;

  typedef struct {
    logic            pop_valid;
    vrbq_pkg::kind_t kind;
    logic [63:0]     payload;
    logic            accepted;
    logic [31:0]     overruns;
    logic [9:0]      used;
    logic [9:0]      peak;
  } queue_reply_t;

  // shadow copy of the ring and its bookkeeping
  vrbq_pkg::byte_t ring [QUEUE_BYTES];
  int unsigned     wr_ptr;
  int unsigned     rd_ptr;
  int unsigned     peak_used;
  logic [31:0]     drop_count;
  vrbq_pkg::len_t  kind_len [vrbq_pkg::KIND_COUNT];
  queue_reply_t    expected_replies [$];

  // zero means a bare type byte; anything past a full payload saturates
  function automatic int unsigned record_bytes(input vrbq_pkg::len_t raw);
    if (raw == 0) return 1;
    if (raw > MAX_PAYLOAD_BYTES + 1) return MAX_PAYLOAD_BYTES + 1;
    return raw;
  endfunction

  function automatic int unsigned ring_fill();
    return (wr_ptr + QUEUE_BYTES - rd_ptr) % QUEUE_BYTES;
  endfunction

  // advance the shadow ring by one request and return what the block should report
  function automatic queue_reply_t apply_request(input logic op, input vrbq_pkg::kind_t kind,
                                                 input logic [63:0] payload);
    queue_reply_t    r;
    int unsigned     fill;
    int unsigned     n;
    vrbq_pkg::kind_t k;
    r.pop_valid = 1'b0;
    r.kind      = '0;
    r.payload   = '0;
    r.accepted  = 1'b0;
    if (op != REQ_POP) begin
      fill = ring_fill();
      if (fill > peak_used) peak_used = fill;
      n = record_bytes(kind_len[kind]);
      if (QUEUE_BYTES - 1 - fill >= n) begin
        ring[wr_ptr] = {5'b0, kind};
        wr_ptr = (wr_ptr + 1) % QUEUE_BYTES;
        for (int i = 0; i < n - 1; i++) begin
          ring[wr_ptr] = payload[8*i +: 8];
          wr_ptr = (wr_ptr + 1) % QUEUE_BYTES;
        end
        r.accepted = 1'b1;
      end else begin
        drop_count++;
      end
    end else if (wr_ptr != rd_ptr) begin
      // length of the record comes from the register current at pop time
      k = ring[rd_ptr][2:0];
      rd_ptr = (rd_ptr + 1) % QUEUE_BYTES;
      n = record_bytes(kind_len[k]);
      for (int i = 0; i < n - 1; i++) begin
        r.payload[8*i +: 8] = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % QUEUE_BYTES;
      end
      r.pop_valid = 1'b1;
      r.kind      = k;
    end
    r.overruns = drop_count;
    r.used     = 10'(ring_fill());
    r.peak     = 10'(peak_used);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (!rst_n) begin
      wr_ptr     = 0;
      rd_ptr     = 0;
      peak_used  = 0;
      drop_count = '0;
      mismatches = 0;
      foreach (kind_len[k]) kind_len[k] = 4'd1;
      expected_replies.delete();
    end else begin
      // register writes; indexes past the last kind are ignored
      if (cfg_valid && cfg_ready && cfg_index < vrbq_pkg::KIND_COUNT)
        kind_len[cfg_index[2:0]] = cfg_data;

      // results are compared before the request of this edge is predicted
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result transaction: tuser=0x%0h tdata=0x%0h",
                 out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("pop_valid",      want.pop_valid, out_tuser[0]);
          check_field("popped_kind",    want.kind,      out_tuser[3:1]);
          check_field("push_accepted",  want.accepted,  out_tuser[4]);
          check_field("popped_payload", want.payload,   out_tdata[63:0]);
          check_field("overrun_count",  want.overruns,  out_tdata[95:64]);
          check_field("used_bytes",     want.used,      out_tdata[105:96]);
          check_field("used_peak",      want.peak,      out_tdata[115:106]);
        end
      end

      if (in_tvalid && in_tready)
        expected_replies.push_back(apply_request(in_tuser[0], in_tuser[3:1], in_tdata));
    end
    outstanding = expected_replies.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import vrbq_pkg::*;

  localparam logic                 REQ_PUSH           = 1'b0;
  localparam logic                 REQ_POP            = 1'b1;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_CFG_INDEX = CFG_IDX_W'(KIND_COUNT);

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [3:0]           cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata   = '0;   // event_payload
  logic [3:0]           in_tuser   = '0;   // req_type, event_kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // popped_payload, overrun_count, used_bytes, used_peak, zero pad
  logic [119:0]         out_tdata;
  // pop_valid, popped_kind, push_accepted
  logic [4:0]           out_tuser;
  int                   mismatches;
  int                   outstanding;

  int   sender_idle_pct   = 29;
  int   receiver_idle_pct = 68;
  len_t next_len [KIND_COUNT];

  variable_record_byte_ring_queue u_dut (.*);

  ring_queue_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side stalls at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // valid stays high after the transaction until the next request or a drain
  task automatic send_request(input logic op, input kind_t kind, input logic [63:0] payload);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {kind, op};
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
  endtask

  // kind and payload are don't-care on a pop, so they carry noise
  task automatic pop_record();
    send_request(REQ_POP, kind_t'($urandom_range(7)), {$urandom, $urandom});
  endtask

  task automatic wait_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // writes all length registers, optionally one write to an unmapped index
  task automatic program_lengths(input bit poke_unmapped);
    for (int k = 0; k < KIND_COUNT + int'(poke_unmapped); k++) begin
      cfg_valid <= 1'b1;
      if (k < KIND_COUNT) begin
        cfg_index <= CFG_IDX_W'(k);
        cfg_data  <= next_len[k];
      end else begin
        cfg_index <= UNMAPPED_CFG_INDEX;
        cfg_data  <= 4'($urandom);
      end
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int push_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pop after reset, then a record that is only a type byte
    pop_record();
    send_request(REQ_PUSH, 3'd0, '1);
    pop_record();
    wait_replies();

    // zero length, saturated length and every kind once
    next_len = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd9, 4'd15, 4'd9};
    program_lengths(1'b0);
    send_request(REQ_PUSH, 3'd0, '1);
    send_request(REQ_PUSH, 3'd6, '1);
    send_request(REQ_PUSH, 3'd7, '0);
    send_request(REQ_PUSH, 3'd2, 64'h0123_4567_89ab_cdef);
    send_request(REQ_PUSH, 3'd4, 64'ha5a5_5a5a_f00f_0ff0);
    send_request(REQ_PUSH, 3'd3, {$urandom, $urandom});
    send_request(REQ_PUSH, 3'd5, '1);
    send_request(REQ_PUSH, 3'd1, '1);
    repeat (8) pop_record();

    // shrink kind 7 while a record of it is queued: the leftover bytes
    // read back as a kind 3 record and a kind 2 record, then empty
    send_request(REQ_PUSH, 3'd7, 64'hee52_4433_2211_fbab);
    wait_replies();
    next_len[7] = 4'd2;
    program_lengths(1'b0);
    repeat (4) pop_record();
    wait_replies();

    // full-length records pushed and popped in turn until every ring byte
    // has been written once; after that any length change is safe
    foreach (next_len[k]) next_len[k] = 4'd9;
    program_lengths(1'b1);
    repeat (120) begin
      send_request(REQ_PUSH, kind_t'($urandom_range(7)), {$urandom, $urandom});
      pop_record();
    end

    // random phases, each with its own lengths and push/pop mix
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        sender_idle_pct   = 68;
        receiver_idle_pct = 29;
      end
      if (p == 6) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      wait_replies();
      foreach (next_len[k]) begin
        case (p)
          1:       next_len[k] = 4'd9;
          3:       next_len[k] = 4'd1;
          5:       next_len[k] = 4'd15;
          6:       next_len[k] = 4'd0;
          default: next_len[k] = len_t'($urandom_range(15));
        endcase
      end
      case (p)
        0:       push_pct = 80;
        1:       push_pct = 85;
        2:       push_pct = 30;
        3:       push_pct = 75;
        4:       push_pct = 25;
        5:       push_pct = 90;
        6:       push_pct = 50;
        default: push_pct = 60;
      endcase
      program_lengths(p == 4);
      repeat (200) begin
        if ($urandom_range(99) < push_pct)
          send_request(REQ_PUSH, kind_t'($urandom_range(7)), {$urandom, $urandom});
        else
          pop_record();
      end
    end

    wait_replies();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
